>>> rtl/kcc_pkg.sv
// ============================================================================
// kcc_pkg
// Types, constants and command/status bundles shared by the connection cache.
// ============================================================================
package kcc_pkg;

    localparam int SLOTS   = 32;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int NEXT_W  = 6;
    localparam logic [NEXT_W-1:0] NIL = 6'd63;
    localparam int KEY_W   = 64;
    localparam int HND_W   = 16;
    localparam int TIME_W  = 48;
    localparam int AGE_W   = 31;
    localparam int SIU_W   = 6;
    localparam int ADDR_W  = 3;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_STORE  = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_HIT      = 3'd0,
        KIND_MISS     = 3'd1,
        KIND_STORED   = 3'd2,
        KIND_REFUSED  = 3'd3,
        KIND_NO_SLOT  = 3'd4,
        KIND_CLOSED   = 3'd5,
        KIND_FLUSHED  = 3'd6
    } kind_t;

    typedef enum logic {
        REG_MAX_AGE      = 1'b0,
        REG_SLOTS_IN_USE = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        SA_GR = 2'd0,
        SA_P  = 2'd1,
        SA_Q  = 2'd2
    } sa_sel_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [KEY_W-1:0]  dest_key;
        logic [HND_W-1:0]  conn_handle;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [HND_W-1:0] out_handle;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic    latch;
        logic    start;
        logic    pos_zero;
        logic    pos_last;
        logic    pos_step;
        logic    move_front;
        logic    drop_head;
        logic    alloc;
        logic    grp_front;
        logic    next_to_s;
        logic    unlink_q;
        logic    p_from_gr;
        logic    p_from_q;
        logic    p_from_next;
        logic    q_load;
        logic    flush_clear;
        logic    emit;
        logic    finish;
        kind_t   kind;
        sa_sel_t sa;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       pool_ready;
        logic       age_zero;
        logic       free_empty;
        logic       group_empty;
        logic       pos_ge_count;
        logic       key_match;
        logic       exp_lt_now;
        logic       next_nil;
        logic       emit_ok;
    } stat_t;

endpackage

>>> rtl/kcc_ctrl.sv
// ============================================================================
// kcc_ctrl
// Sequencer: steps each request through search, chain walk and result issue.
// ============================================================================
module kcc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  kcc_pkg::stat_t st,
    output kcc_pkg::cmd_t  cmd
);

    typedef enum logic [17:0] {
        S_IDLE    = 18'h00001,
        S_DISP    = 18'h00002,
        S_START   = 18'h00004,
        S_LFIND   = 18'h00008,
        S_LMOVE   = 18'h00010,
        S_LCHECK  = 18'h00020,
        S_LMISS   = 18'h00040,
        S_SCHECK  = 18'h00080,
        S_SEVICT  = 18'h00100,
        S_SALLOC  = 18'h00200,
        S_SFIND   = 18'h00400,
        S_SPRUNE  = 18'h00800,
        S_SFRONT  = 18'h01000,
        S_WA      = 18'h02000,
        S_WB      = 18'h04000,
        S_FGROUP  = 18'h08000,
        S_FCHAIN  = 18'h10000,
        S_DONE    = 18'h20000
    } state_t;

    state_t state_reg, state_next, st_raw;
    kcc_pkg::cmd_t c;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        c      = '0;
        c.kind = kcc_pkg::KIND_HIT;
        c.sa   = kcc_pkg::SA_GR;
        st_raw = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    c.latch = 1'b1;
                    st_raw  = S_DISP;
                end
            end
            S_DISP:
            begin
                c.pos_zero = 1'b1;
                if (st.op == kcc_pkg::OP_LOOKUP || st.op == kcc_pkg::OP_STORE)
                begin
                    if (!st.pool_ready)
                        st_raw = S_START;
                    else if (st.op == kcc_pkg::OP_LOOKUP)
                        st_raw = S_LFIND;
                    else
                        st_raw = S_SCHECK;
                end
                else if (st.op == kcc_pkg::OP_FLUSH)
                begin
                    if (st.pool_ready)
                        st_raw = S_FGROUP;
                    else
                    begin
                        c.emit = 1'b1;
                        c.kind = kcc_pkg::KIND_FLUSHED;
                        st_raw = S_DONE;
                    end
                end
                else
                    st_raw = S_IDLE;
            end
            S_START:
            begin
                c.start    = 1'b1;
                c.pos_zero = 1'b1;
                st_raw = (st.op == kcc_pkg::OP_LOOKUP) ? S_LFIND : S_SCHECK;
            end
            S_LFIND:
            begin
                if (st.pos_ge_count)
                begin
                    c.emit = 1'b1;
                    c.kind = kcc_pkg::KIND_MISS;
                    st_raw = S_DONE;
                end
                else if (st.key_match)
                    st_raw = S_LMOVE;
                else
                    c.pos_step = 1'b1;
            end
            S_LMOVE:
            begin
                c.move_front = 1'b1;
                c.pos_zero   = 1'b1;
                st_raw       = S_LCHECK;
            end
            S_LCHECK:
            begin
                c.emit      = 1'b1;
                c.drop_head = 1'b1;
                if (st.exp_lt_now)
                begin
                    c.kind = kcc_pkg::KIND_CLOSED;
                    if (st.next_nil)
                        st_raw = S_LMISS;
                end
                else
                begin
                    c.kind = kcc_pkg::KIND_HIT;
                    st_raw = S_DONE;
                end
            end
            S_LMISS:
            begin
                c.emit = 1'b1;
                c.kind = kcc_pkg::KIND_MISS;
                st_raw = S_DONE;
            end
            S_SCHECK:
            begin
                if (st.age_zero)
                begin
                    c.emit = 1'b1;
                    c.kind = kcc_pkg::KIND_REFUSED;
                    st_raw = S_DONE;
                end
                else if (st.free_empty)
                begin
                    if (st.group_empty)
                    begin
                        c.emit = 1'b1;
                        c.kind = kcc_pkg::KIND_NO_SLOT;
                        st_raw = S_DONE;
                    end
                    else
                    begin
                        c.pos_last = 1'b1;
                        st_raw     = S_SEVICT;
                    end
                end
                else
                    st_raw = S_SALLOC;
            end
            S_SEVICT:
            begin
                c.emit      = 1'b1;
                c.kind      = kcc_pkg::KIND_CLOSED;
                c.drop_head = 1'b1;
                st_raw      = S_SALLOC;
            end
            S_SALLOC:
            begin
                c.alloc    = 1'b1;
                c.pos_zero = 1'b1;
                st_raw     = S_SFIND;
            end
            S_SFIND:
            begin
                if (st.pos_ge_count)
                    st_raw = S_SFRONT;
                else if (st.key_match)
                    st_raw = S_SPRUNE;
                else
                    c.pos_step = 1'b1;
            end
            S_SPRUNE:
            begin
                if (!st.exp_lt_now)
                begin
                    c.p_from_gr = 1'b1;
                    st_raw      = S_WA;
                end
                else
                begin
                    c.emit      = 1'b1;
                    c.kind      = kcc_pkg::KIND_CLOSED;
                    c.drop_head = 1'b1;
                    if (st.next_nil)
                        st_raw = S_SFRONT;
                end
            end
            S_SFRONT:
            begin
                c.emit      = 1'b1;
                c.kind      = kcc_pkg::KIND_STORED;
                c.grp_front = 1'b1;
                st_raw      = S_DONE;
            end
            S_WA:
            begin
                c.sa = kcc_pkg::SA_P;
                if (st.next_nil)
                begin
                    c.next_to_s = 1'b1;
                    c.emit      = 1'b1;
                    c.kind      = kcc_pkg::KIND_STORED;
                    st_raw      = S_DONE;
                end
                else
                begin
                    c.q_load = 1'b1;
                    st_raw   = S_WB;
                end
            end
            S_WB:
            begin
                c.sa   = kcc_pkg::SA_Q;
                st_raw = S_WA;
                if (st.exp_lt_now)
                begin
                    c.emit     = 1'b1;
                    c.kind     = kcc_pkg::KIND_CLOSED;
                    c.unlink_q = 1'b1;
                end
                else
                    c.p_from_q = 1'b1;
            end
            S_FGROUP:
            begin
                if (st.pos_ge_count)
                begin
                    c.flush_clear = 1'b1;
                    c.emit        = 1'b1;
                    c.kind        = kcc_pkg::KIND_FLUSHED;
                    st_raw        = S_DONE;
                end
                else
                begin
                    c.p_from_gr = 1'b1;
                    st_raw      = S_FCHAIN;
                end
            end
            S_FCHAIN:
            begin
                c.sa   = kcc_pkg::SA_P;
                c.emit = 1'b1;
                c.kind = kcc_pkg::KIND_CLOSED;
                if (st.next_nil)
                begin
                    c.pos_step = 1'b1;
                    st_raw     = S_FGROUP;
                end
                else
                    c.p_from_next = 1'b1;
            end
            S_DONE:
            begin
                c.finish = 1'b1;
                st_raw   = S_IDLE;
            end
            default:
                st_raw = S_IDLE;
        endcase
    end

    // hold everything while the result path is full
    always_comb
    begin
        cmd        = c;
        state_next = st_raw;
        if ((c.emit || c.finish) && !st.emit_ok)
        begin
            cmd        = '0;
            cmd.kind   = kcc_pkg::KIND_HIT;
            cmd.sa     = c.sa;
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/kcc_datapath.sv
// ============================================================================
// kcc_datapath
// Slot store, recency list, free queue and the result staging registers.
// ============================================================================
module kcc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kcc_pkg::cmd_t                   cmd,
    output kcc_pkg::stat_t                  st,
    input  kcc_pkg::in_item_t               in_data,
    input  logic [kcc_pkg::AGE_W-1:0]       max_age,
    input  logic [kcc_pkg::SIU_W-1:0]       slots_in_use,
    output logic                            out_valid,
    input  logic                            out_ready,
    output kcc_pkg::out_item_t              out_data
);

    localparam int IW = kcc_pkg::IDX_W;
    localparam int CW = kcc_pkg::CNT_W;
    localparam int NW = kcc_pkg::NEXT_W;
    localparam int TW = kcc_pkg::TIME_W;

    kcc_pkg::in_item_t item_reg;

    logic [kcc_pkg::KEY_W-1:0] slot_key_reg    [kcc_pkg::SLOTS];
    logic [kcc_pkg::HND_W-1:0] slot_handle_reg [kcc_pkg::SLOTS];
    logic [TW-1:0]             slot_expiry_reg [kcc_pkg::SLOTS];
    logic [NW-1:0]             slot_next_reg   [kcc_pkg::SLOTS];

    logic [IW-1:0] recency_reg  [kcc_pkg::SLOTS];
    logic [IW-1:0] recency_next [kcc_pkg::SLOTS];
    logic [IW-1:0] fq_reg       [kcc_pkg::SLOTS];

    logic [CW-1:0] group_count_reg, group_count_next;
    logic [CW-1:0] free_count_reg, free_count_next;
    logic [IW-1:0] free_head_reg, free_head_next;
    logic          pool_ready_reg, pool_ready_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [IW-1:0] p_reg, p_next;
    logic [IW-1:0] q_reg, q_next;
    logic [IW-1:0] s_reg;

    logic [2:0]                pend_kind_reg;
    logic [kcc_pkg::HND_W-1:0] pend_handle_reg;
    logic                      pend_v_reg, pend_v_next;
    kcc_pkg::out_item_t        out_reg;
    logic                      out_v_reg, out_v_next;

    logic [IW-1:0]             pos_idx, gr_rd, sa_idx, fq_rd, push_idx, push_val;
    logic [kcc_pkg::KEY_W-1:0] key_rd;
    logic [kcc_pkg::HND_W-1:0] handle_rd, emit_handle;
    logic [TW-1:0]             exp_rd, exp_new;
    logic [TW:0]               exp_sum;
    logic [NW-1:0]             next_rd;
    logic [CW:0]               push_sum;
    logic [CW-1:0]             start_count;
    logic                      next_nil, push_en, out_free, emit_ok, count_full;

    assign pos_idx = pos_reg[IW-1:0];
    assign gr_rd   = recency_reg[pos_idx];

    always_comb
    begin
        case (cmd.sa)
            kcc_pkg::SA_GR: sa_idx = gr_rd;
            kcc_pkg::SA_P:  sa_idx = p_reg;
            kcc_pkg::SA_Q:  sa_idx = q_reg;
            default:        sa_idx = gr_rd;
        endcase
    end

    assign key_rd    = slot_key_reg[sa_idx];
    assign handle_rd = slot_handle_reg[sa_idx];
    assign exp_rd    = slot_expiry_reg[sa_idx];
    assign next_rd   = slot_next_reg[sa_idx];
    assign next_nil  = (next_rd >= NW'(kcc_pkg::SLOTS));
    assign fq_rd     = fq_reg[free_head_reg];

    assign count_full = (free_count_reg >= CW'(kcc_pkg::SLOTS));
    assign push_en    = (cmd.drop_head || cmd.unlink_q) && !count_full;
    assign push_val   = cmd.unlink_q ? q_reg : gr_rd;
    assign push_sum   = (CW+1)'(free_head_reg) + (CW+1)'(free_count_reg);
    assign push_idx   = (push_sum >= (CW+1)'(kcc_pkg::SLOTS))
                        ? IW'(push_sum - (CW+1)'(kcc_pkg::SLOTS)) : IW'(push_sum);

    assign exp_sum = (TW+1)'(item_reg.now_ms) + (TW+1)'(max_age);
    assign exp_new = exp_sum[TW] ? {TW{1'b1}} : exp_sum[TW-1:0];

    assign start_count = (slots_in_use > kcc_pkg::SIU_W'(kcc_pkg::SLOTS))
                         ? CW'(kcc_pkg::SLOTS) : CW'(slots_in_use);

    assign out_free = !out_v_reg || out_ready;
    assign emit_ok  = !pend_v_reg || out_free;

    assign st.op           = item_reg.operation;
    assign st.pool_ready   = pool_ready_reg;
    assign st.age_zero     = (max_age == '0);
    assign st.free_empty   = (free_count_reg == '0);
    assign st.group_empty  = (group_count_reg == '0);
    assign st.pos_ge_count = (pos_reg >= group_count_reg);
    assign st.key_match    = (key_rd == item_reg.dest_key);
    assign st.exp_lt_now   = (exp_rd < item_reg.now_ms);
    assign st.next_nil     = next_nil;
    assign st.emit_ok      = emit_ok;

    // recency list: move to front, drop a group, advance a head, add a group
    always_comb
    begin
        recency_next = recency_reg;
        if (cmd.move_front)
        begin
            for (int j = 1; j < kcc_pkg::SLOTS; j++)
                if (CW'(j) <= pos_reg)
                    recency_next[j] = recency_reg[j-1];
            recency_next[0] = gr_rd;
        end
        if (cmd.drop_head)
        begin
            if (next_nil)
            begin
                for (int j = 0; j < kcc_pkg::SLOTS - 1; j++)
                    if (CW'(j) >= pos_reg && CW'(j + 1) < group_count_reg)
                        recency_next[j] = recency_reg[j+1];
            end
            else
                recency_next[pos_idx] = next_rd[IW-1:0];
        end
        if (cmd.grp_front && (group_count_reg < CW'(kcc_pkg::SLOTS)))
        begin
            for (int j = 1; j < kcc_pkg::SLOTS; j++)
                recency_next[j] = recency_reg[j-1];
            recency_next[0] = s_reg;
        end
    end

    always_comb
    begin
        group_count_next = group_count_reg;
        if (cmd.start || cmd.flush_clear)
            group_count_next = '0;
        else if (cmd.drop_head && next_nil && group_count_reg != '0)
            group_count_next = group_count_reg - 1'b1;
        else if (cmd.grp_front && (group_count_reg < CW'(kcc_pkg::SLOTS)))
            group_count_next = group_count_reg + 1'b1;

        free_count_next = free_count_reg;
        free_head_next  = free_head_reg;
        pool_ready_next = pool_ready_reg;
        if (cmd.start)
        begin
            free_count_next = start_count;
            free_head_next  = '0;
            pool_ready_next = 1'b1;
        end
        else if (cmd.flush_clear)
        begin
            free_count_next = '0;
            free_head_next  = '0;
            pool_ready_next = 1'b0;
        end
        else if (cmd.alloc)
        begin
            free_count_next = free_count_reg - 1'b1;
            free_head_next  = (free_head_reg == IW'(kcc_pkg::SLOTS - 1))
                              ? '0 : free_head_reg + 1'b1;
        end
        else if (push_en)
            free_count_next = free_count_reg + 1'b1;

        pos_next = pos_reg;
        if (cmd.pos_zero)
            pos_next = '0;
        else if (cmd.pos_last)
            pos_next = group_count_reg - 1'b1;
        else if (cmd.pos_step)
            pos_next = pos_reg + 1'b1;

        p_next = p_reg;
        if (cmd.p_from_gr)
            p_next = gr_rd;
        else if (cmd.p_from_q)
            p_next = q_reg;
        else if (cmd.p_from_next)
            p_next = next_rd[IW-1:0];

        q_next = cmd.q_load ? next_rd[IW-1:0] : q_reg;
    end

    // result staging: one pending result, released when the next result is emitted or the request finishes
    assign emit_handle = (cmd.kind == kcc_pkg::KIND_HIT || cmd.kind == kcc_pkg::KIND_CLOSED)
                         ? handle_rd : '0;

    always_comb
    begin
        pend_v_next = pend_v_reg;
        out_v_next  = out_v_reg && !out_ready;
        if (cmd.emit)
        begin
            pend_v_next = 1'b1;
            if (pend_v_reg)
                out_v_next = 1'b1;
        end
        else if (cmd.finish && pend_v_reg)
        begin
            pend_v_next = 1'b0;
            out_v_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kcc_pkg::SLOTS; i++)
            begin
                recency_reg[i] <= '0;
                fq_reg[i]      <= IW'(i);
            end
            group_count_reg <= '0;
            free_count_reg  <= '0;
            free_head_reg   <= '0;
            pool_ready_reg  <= 1'b0;
            pos_reg         <= '0;
            pend_v_reg      <= 1'b0;
            out_v_reg       <= 1'b0;
        end
        else
        begin
            recency_reg     <= recency_next;
            group_count_reg <= group_count_next;
            free_count_reg  <= free_count_next;
            free_head_reg   <= free_head_next;
            pool_ready_reg  <= pool_ready_next;
            pos_reg         <= pos_next;
            pend_v_reg      <= pend_v_next;
            out_v_reg       <= out_v_next;
            if (cmd.start)
            begin
                for (int i = 0; i < kcc_pkg::SLOTS; i++)
                    fq_reg[i] <= IW'(i);
            end
            else if (push_en)
                fq_reg[push_idx] <= push_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            item_reg <= in_data;
        p_reg <= p_next;
        q_reg <= q_next;
        if (cmd.alloc)
        begin
            s_reg                  <= fq_rd;
            slot_key_reg[fq_rd]    <= item_reg.dest_key;
            slot_handle_reg[fq_rd] <= item_reg.conn_handle;
            slot_expiry_reg[fq_rd] <= exp_new;
            slot_next_reg[fq_rd]   <= kcc_pkg::NIL;
        end
        if (cmd.next_to_s)
            slot_next_reg[p_reg] <= NW'(s_reg);
        else if (cmd.unlink_q)
            slot_next_reg[p_reg] <= next_rd;
        if (cmd.emit)
        begin
            pend_kind_reg   <= cmd.kind;
            pend_handle_reg <= emit_handle;
        end
        if (cmd.emit && pend_v_reg)
            out_reg <= '{kind: pend_kind_reg, out_handle: pend_handle_reg, last: 1'b0};
        else if (cmd.finish && pend_v_reg)
            out_reg <= '{kind: pend_kind_reg, out_handle: pend_handle_reg, last: 1'b1};
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/keyed_connection_cache_lru.sv
// ============================================================================
// keyed_connection_cache_lru
// Pool of idle connection handles grouped by key, groups in LRU order.
// ============================================================================
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------
//  request   | in_valid / in_ready          | in_data  (kcc_pkg::in_item_t)
//  result    | out_valid / out_ready        | out_data (kcc_pkg::out_item_t)
//  config    | psel penable pwrite pready   | paddr, pwdata, prdata
//
//  One request is worked at a time. A request passes through accept,
//  dispatch and finish, the key search (group by group), the chain walk
//  (entry by entry, through states S_WA and S_WB on the store side)
//  and the fixed steps where needed (pool start, move to front, store check,
//  slot take, group insert). Results are issued during those steps.
//  in_ready is high only while the sequencer is idle. Results leave through
//  a pending stage and an output register; a full output stalls the sequencer.
//  Reset empties the pool; the first lookup or store fills the free queue.
//  Configuration is taken at any time, always with pready high.
//
module keyed_connection_cache_lru (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  kcc_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output kcc_pkg::out_item_t            out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [kcc_pkg::AGE_W-1:0] max_age_reg, max_age_next;
    logic [kcc_pkg::SIU_W-1:0] siu_reg, siu_next;
    logic                      wr_en;
    kcc_pkg::reg_idx_t         reg_sel;
    kcc_pkg::cmd_t             cmd;
    kcc_pkg::stat_t            st;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = kcc_pkg::reg_idx_t'(paddr[2]);

    // register file: word address picks the register, byte bits ignored
    always_comb
    begin
        max_age_next = max_age_reg;
        siu_next     = siu_reg;
        if (wr_en)
        begin
            case (reg_sel)
                kcc_pkg::REG_MAX_AGE:      max_age_next = pwdata[kcc_pkg::AGE_W-1:0];
                kcc_pkg::REG_SLOTS_IN_USE: siu_next     = pwdata[kcc_pkg::SIU_W-1:0];
                default:                   max_age_next = max_age_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            kcc_pkg::REG_MAX_AGE:      prdata = {1'b0, max_age_reg};
            kcc_pkg::REG_SLOTS_IN_USE: prdata = {26'b0, siu_reg};
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg <= '0;
            siu_reg     <= kcc_pkg::SIU_W'(32);
        end
        else
        begin
            max_age_reg <= max_age_next;
            siu_reg     <= siu_next;
        end
    end

    // sequencer: drives commands, reads back status
    kcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // slot store, lists and result staging
    kcc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .in_data      (in_data),
        .max_age      (max_age_reg),
        .slots_in_use (siu_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule
